>>> rtl/crp_pkg.sv
package crp_pkg;

  localparam int unsigned TotalW = 33;
  localparam int unsigned CountW = 25;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_LEN     = 5'b00001,
    PH_LABEL   = 5'b00010,
    PH_VERSION = 5'b00100,
    PH_SIZE    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    CLS_LEN     = 3'd0,
    CLS_LABEL   = 3'd1,
    CLS_VERSION = 3'd2,
    CLS_SIZE    = 3'd3,
    CLS_PAYLOAD = 3'd4,
    CLS_NONE    = 3'd5
  } cls_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_FILE_TOO_BIG  = 3'd1,
    ERR_ZERO_LABEL    = 3'd2,
    ERR_TRUNC_HEADER  = 3'd3,
    ERR_TRUNC_LABEL   = 3'd4,
    ERR_TRUNC_PAYLOAD = 3'd5,
    ERR_TOO_MANY_RECS = 3'd6
  } err_e;

  typedef enum logic [0:0] {
    CFG_MAX_FILE_BYTES = 1'b0,
    CFG_MAX_RECORDS    = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    CMD_DATA = 1'b0,
    CMD_EOF  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [7:0]  byte_out;
    cls_e        field_class;
    logic [23:0] record_index;
    logic        record_done;
    logic [15:0] label_len;
    logic [15:0] version;
    logic [31:0] pay_size;
    err_e        error_code;
    logic        file_ok;
  } result_t;

  function automatic cls_e phase_class(phase_e ph);
    cls_e c;
    case (ph)
      PH_LEN:     c = CLS_LEN;
      PH_LABEL:   c = CLS_LABEL;
      PH_VERSION: c = CLS_VERSION;
      PH_SIZE:    c = CLS_SIZE;
      PH_PAYLOAD: c = CLS_PAYLOAD;
      default:    c = CLS_NONE;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/chunk_record_parser.sv
// Streaming parser for a file of length-tagged records, one byte request per
// clock. Each record is a 16-bit little-endian label length, the label, a
// 16-bit version, a 32-bit payload size and the payload; an end-of-file request
// (cmd_i = 1) closes the file, reports file_ok_o or the first error, and clears
// all parse state for the next file. Every request yields exactly one result,
// registered in the output or skid register; the parser takes one request every
// cycle and only raises in_stall_o while its two-entry output buffer (result
// register plus skid register) is full because the consumer stalls. Limits
// max_file_bytes (index 0) and max_records (index 1) survive end of file and
// are to be written only while the parser is idle.
module chunk_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  cmd_i,
  input  logic [7:0]  data_byte_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_out_o,
  output logic [2:0]  field_class_o,
  output logic [23:0] record_index_o,
  output logic        record_done_o,
  output logic [15:0] label_length_out_o,
  output logic [15:0] version_out_o,
  output logic [31:0] payload_size_out_o,
  output logic [2:0]  error_code_o,
  output logic        file_ok_o
);

  logic [31:0] max_bytes_q;
  logic [23:0] max_recs_q;

  crp_pkg::phase_e              phase_q, phase_d;
  logic [1:0]                   fbi_q, fbi_d;
  logic [15:0]                  len_q, len_d;
  logic [15:0]                  ver_q, ver_d;
  logic [31:0]                  size_q, size_d;
  logic [31:0]                  rem_q, rem_d;
  logic [crp_pkg::TotalW-1:0]   total_q, total_d;
  logic [crp_pkg::CountW-1:0]   count_q, count_d;
  crp_pkg::err_e                err_q, err_d;

  crp_pkg::result_t res;
  crp_pkg::result_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q;

  logic                       in_acc;
  logic                       out_free;
  logic [crp_pkg::TotalW-1:0] total_inc;
  logic [crp_pkg::CountW-1:0] count_inc;
  logic [31:0]                rem_dec;
  logic [15:0]                len_new;
  logic [31:0]                size_new;
  logic [31:0]                byte_shifted;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= '1;
      max_recs_q  <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (crp_pkg::cfg_idx_e'(cfg_index_i))
        crp_pkg::CFG_MAX_FILE_BYTES: max_bytes_q <= cfg_data_i;
        crp_pkg::CFG_MAX_RECORDS:    max_recs_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign total_inc    = (total_q == crp_pkg::TotalMax) ? total_q
                        : total_q + crp_pkg::TotalW'(1);
  assign count_inc    = (count_q == crp_pkg::CountMax) ? count_q
                        : count_q + crp_pkg::CountW'(1);
  assign rem_dec      = (rem_q != 32'd0) ? rem_q - 32'd1 : rem_q;
  assign len_new      = len_q | {data_byte_i, 8'h00};
  assign byte_shifted = {24'h0, data_byte_i} << {fbi_q, 3'b000};
  assign size_new     = (fbi_q == 2'd0) ? {24'h0, data_byte_i} : (size_q | byte_shifted);

  always_comb begin
    phase_d = phase_q;
    fbi_d   = fbi_q;
    len_d   = len_q;
    ver_d   = ver_q;
    size_d  = size_q;
    rem_d   = rem_q;
    total_d = total_q;
    count_d = count_q;
    err_d   = err_q;

    res.byte_out     = data_byte_i;
    res.field_class  = crp_pkg::CLS_NONE;
    res.record_index = count_q[23:0];
    res.record_done  = 1'b0;
    res.file_ok      = 1'b0;

    if (crp_pkg::cmd_e'(cmd_i) == crp_pkg::CMD_EOF) begin
      res.byte_out = 8'h00;
      if (err_q == crp_pkg::ERR_NONE) begin
        if (phase_q == crp_pkg::PH_LEN && fbi_q == 2'd0) res.file_ok = 1'b1;
        else if (phase_q == crp_pkg::PH_LABEL)   err_d = crp_pkg::ERR_TRUNC_LABEL;
        else if (phase_q == crp_pkg::PH_PAYLOAD) err_d = crp_pkg::ERR_TRUNC_PAYLOAD;
        else                                     err_d = crp_pkg::ERR_TRUNC_HEADER;
      end
    end else if (err_q == crp_pkg::ERR_NONE) begin
      total_d = total_inc;
      if (total_inc > {1'b0, max_bytes_q}) begin
        err_d = crp_pkg::ERR_FILE_TOO_BIG;
      end else begin
        res.field_class = crp_pkg::phase_class(phase_q);
        case (phase_q)
          crp_pkg::PH_LEN: begin
            if (fbi_q == 2'd0) begin
              len_d  = {8'h00, data_byte_i};
              ver_d  = '0;
              size_d = '0;
              fbi_d  = 2'd1;
            end else begin
              len_d = len_new;
              fbi_d = 2'd0;
              if (len_new == 16'd0) begin
                err_d = crp_pkg::ERR_ZERO_LABEL;
              end else begin
                rem_d   = {16'h0, len_new};
                phase_d = crp_pkg::PH_LABEL;
              end
            end
          end
          crp_pkg::PH_LABEL: begin
            rem_d = rem_dec;
            if (rem_dec == 32'd0) begin
              phase_d = crp_pkg::PH_VERSION;
              fbi_d   = 2'd0;
            end
          end
          crp_pkg::PH_VERSION: begin
            if (fbi_q == 2'd0) begin
              ver_d = {8'h00, data_byte_i};
              fbi_d = 2'd1;
            end else begin
              ver_d   = ver_q | {data_byte_i, 8'h00};
              fbi_d   = 2'd0;
              phase_d = crp_pkg::PH_SIZE;
            end
          end
          crp_pkg::PH_SIZE: begin
            size_d = size_new;
            if (fbi_q == 2'd3) begin
              rem_d = size_new;
              fbi_d = 2'd0;
              if (size_new == 32'd0) begin
                // empty payload: record ends on the last size byte
                res.record_done = 1'b1;
                count_d         = count_inc;
                phase_d         = crp_pkg::PH_LEN;
                if (count_inc > {1'b0, max_recs_q}) err_d = crp_pkg::ERR_TOO_MANY_RECS;
              end else begin
                phase_d = crp_pkg::PH_PAYLOAD;
              end
            end else begin
              fbi_d = fbi_q + 2'd1;
            end
          end
          crp_pkg::PH_PAYLOAD: begin
            rem_d = rem_dec;
            if (rem_dec == 32'd0) begin
              res.record_done = 1'b1;
              count_d         = count_inc;
              phase_d         = crp_pkg::PH_LEN;
              fbi_d           = 2'd0;
              if (count_inc > {1'b0, max_recs_q}) err_d = crp_pkg::ERR_TOO_MANY_RECS;
            end
          end
          default: begin
            phase_d = crp_pkg::PH_LEN;
          end
        endcase
      end
    end

    res.label_len  = len_d;
    res.version    = ver_d;
    res.pay_size   = size_d;
    res.error_code = err_d;

    // end of file starts the next file from a clean parse state
    if (crp_pkg::cmd_e'(cmd_i) == crp_pkg::CMD_EOF) begin
      phase_d = crp_pkg::PH_LEN;
      fbi_d   = '0;
      len_d   = '0;
      ver_d   = '0;
      size_d  = '0;
      rem_d   = '0;
      total_d = '0;
      count_d = '0;
      err_d   = crp_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= crp_pkg::PH_LEN;
      fbi_q   <= '0;
      len_q   <= '0;
      ver_q   <= '0;
      size_q  <= '0;
      rem_q   <= '0;
      total_q <= '0;
      count_q <= '0;
      err_q   <= crp_pkg::ERR_NONE;
    end else if (in_acc) begin
      phase_q <= phase_d;
      fbi_q   <= fbi_d;
      len_q   <= len_d;
      ver_q   <= ver_d;
      size_q  <= size_d;
      rem_q   <= rem_d;
      total_q <= total_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q  <= skid_valid_q || in_acc;
        skid_valid_q <= 1'b0;
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (in_acc)  out_q <= res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign byte_out_o         = out_q.byte_out;
  assign field_class_o      = out_q.field_class;
  assign record_index_o     = out_q.record_index;
  assign record_done_o      = out_q.record_done;
  assign label_length_out_o = out_q.label_len;
  assign version_out_o      = out_q.version;
  assign payload_size_out_o = out_q.pay_size;
  assign error_code_o       = out_q.error_code;
  assign file_ok_o          = out_q.file_ok;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while output register is empty");

  a_ok_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.file_ok) |-> (out_q.error_code == crp_pkg::ERR_NONE))
    else $error("file_ok reported together with an error");

  a_done_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.record_done) |->
      (out_q.field_class == crp_pkg::CLS_SIZE || out_q.field_class == crp_pkg::CLS_PAYLOAD))
    else $error("record end outside size or payload field");

  a_fbi_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fbi_q != 2'd0) |->
      (phase_q == crp_pkg::PH_LEN || phase_q == crp_pkg::PH_VERSION
       || phase_q == crp_pkg::PH_SIZE))
    else $error("field byte index set in a phase without multi-byte fields");

  a_error_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && err_q != crp_pkg::ERR_NONE && cmd_i == crp_pkg::CMD_DATA) |=>
      ($stable(phase_q) && $stable(count_q)))
    else $error("parse state moved after a sticky error");

endmodule

>>> tb/chunk_record_parser_tb.sv
`timescale 1ns / 100ps

module chunk_record_parser_tb;

  // Predicts the parser's result for every request and holds them until the
  // matching result comes out.
  class record_scoreboard;
    crp_pkg::result_t           pending_q[$];
    crp_pkg::phase_e            phase;
    logic [1:0]                 byte_sel;
    logic [15:0]                label_len;
    logic [15:0]                version;
    logic [31:0]                pay_size;
    logic [31:0]                left;
    logic [crp_pkg::TotalW-1:0] file_bytes;
    logic [crp_pkg::CountW-1:0] rec_count;
    crp_pkg::err_e              sticky;
    logic [31:0]                lim_bytes;
    logic [23:0]                lim_recs;
    int                         faults;
    int                         checked;
    int                         records_closed;
    int                         files;
    bit [7:0]                   errs_seen;

    function new();
      lim_bytes = 32'hFFFF_FFFF;
      lim_recs  = 24'hFF_FFFF;
      faults = 0;
      checked = 0;
      records_closed = 0;
      files = 0;
      errs_seen = '0;
      clear_file();
    endfunction

    function void clear_file();
      phase      = crp_pkg::PH_LEN;
      byte_sel   = '0;
      label_len  = '0;
      version    = '0;
      pay_size   = '0;
      left       = '0;
      file_bytes = '0;
      rec_count  = '0;
      sticky     = crp_pkg::ERR_NONE;
    endfunction

    function void write_limit(crp_pkg::cfg_idx_e idx, logic [31:0] value);
      if (idx == crp_pkg::CFG_MAX_FILE_BYTES) lim_bytes = value;
      else lim_recs = value[23:0];
    endfunction

    function void close_record();
      if (rec_count != crp_pkg::CountMax) rec_count = rec_count + 1'b1;
      phase    = crp_pkg::PH_LEN;
      byte_sel = '0;
      records_closed++;
      if (rec_count > {1'b0, lim_recs}) sticky = crp_pkg::ERR_TOO_MANY_RECS;
    endfunction

    function void note_request(crp_pkg::cmd_e cmd, logic [7:0] b);
      crp_pkg::result_t r;
      logic [1:0]       k;
      r.byte_out     = b;
      r.field_class  = crp_pkg::CLS_NONE;
      r.record_index = rec_count[23:0];
      r.record_done  = 1'b0;
      r.file_ok      = 1'b0;
      if (cmd == crp_pkg::CMD_EOF) begin
        r.byte_out = '0;
        if (sticky == crp_pkg::ERR_NONE) begin
          if (phase == crp_pkg::PH_LEN && byte_sel == 2'd0) r.file_ok = 1'b1;
          else if (phase == crp_pkg::PH_LABEL) sticky = crp_pkg::ERR_TRUNC_LABEL;
          else if (phase == crp_pkg::PH_PAYLOAD) sticky = crp_pkg::ERR_TRUNC_PAYLOAD;
          else sticky = crp_pkg::ERR_TRUNC_HEADER;
        end
      end else if (sticky == crp_pkg::ERR_NONE) begin
        if (file_bytes != crp_pkg::TotalMax) file_bytes = file_bytes + 1'b1;
        if (file_bytes > {1'b0, lim_bytes}) begin
          sticky = crp_pkg::ERR_FILE_TOO_BIG;
        end else begin
          k = byte_sel;
          case (phase)
            crp_pkg::PH_LEN: begin
              r.field_class = crp_pkg::CLS_LEN;
              if (k == 2'd0) begin
                label_len = {8'h00, b};
                version   = '0;
                pay_size  = '0;
                byte_sel  = 2'd1;
              end else begin
                label_len = {b, label_len[7:0]};
                byte_sel  = 2'd0;
                if (label_len == 16'h0000) begin
                  sticky = crp_pkg::ERR_ZERO_LABEL;
                end else begin
                  left  = {16'h0000, label_len};
                  phase = crp_pkg::PH_LABEL;
                end
              end
            end
            crp_pkg::PH_LABEL: begin
              r.field_class = crp_pkg::CLS_LABEL;
              if (left != 0) left = left - 1;
              if (left == 0) begin
                phase    = crp_pkg::PH_VERSION;
                byte_sel = 2'd0;
              end
            end
            crp_pkg::PH_VERSION: begin
              r.field_class = crp_pkg::CLS_VERSION;
              if (k == 2'd0) begin
                version  = {8'h00, b};
                byte_sel = 2'd1;
              end else begin
                version  = {b, version[7:0]};
                byte_sel = 2'd0;
                phase    = crp_pkg::PH_SIZE;
              end
            end
            crp_pkg::PH_SIZE: begin
              r.field_class = crp_pkg::CLS_SIZE;
              if (k == 2'd0) pay_size = {24'h0, b};
              else pay_size = pay_size | ({24'h0, b} << (8 * int'(k)));
              if (k == 2'd3) begin
                left = pay_size;
                if (left == 0) begin
                  close_record();
                  r.record_done = 1'b1;
                end else begin
                  phase    = crp_pkg::PH_PAYLOAD;
                  byte_sel = 2'd0;
                end
              end else begin
                byte_sel = k + 2'd1;
              end
            end
            default: begin
              r.field_class = crp_pkg::CLS_PAYLOAD;
              if (left != 0) left = left - 1;
              if (left == 0) begin
                close_record();
                r.record_done = 1'b1;
              end
            end
          endcase
        end
      end
      r.label_len  = label_len;
      r.version    = version;
      r.pay_size   = pay_size;
      r.error_code = sticky;
      if (cmd == crp_pkg::CMD_EOF) begin
        clear_file();
        files++;
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(crp_pkg::result_t got);
      crp_pkg::result_t exp;
      bit               bad;
      if (pending_q.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("result with nothing pending: byte=%h cls=%0d err=%0d",
                   got.byte_out, got.field_class, got.error_code);
        return;
      end
      exp = pending_q.pop_front();
      checked++;
      errs_seen[exp.error_code] = 1'b1;
      bad = (got.byte_out !== exp.byte_out) || (got.field_class !== exp.field_class) ||
            (got.record_index !== exp.record_index) ||
            (got.record_done !== exp.record_done) ||
            (got.label_len !== exp.label_len) || (got.version !== exp.version) ||
            (got.pay_size !== exp.pay_size) ||
            (got.error_code !== exp.error_code) || (got.file_ok !== exp.file_ok);
      if (bad) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch at result %0d:", checked);
          $display(
            "  expected byte=%h cls=%0d idx=%0d done=%b len=%h ver=%h size=%h err=%0d ok=%b",
            exp.byte_out, exp.field_class, exp.record_index, exp.record_done,
            exp.label_len, exp.version, exp.pay_size, exp.error_code, exp.file_ok);
          $display(
            "  actual   byte=%h cls=%0d idx=%0d done=%b len=%h ver=%h size=%h err=%0d ok=%b",
            got.byte_out, got.field_class, got.record_index, got.record_done,
            got.label_len, got.version, got.pay_size, got.error_code, got.file_ok);
        end
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [0:0]  cmd_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  byte_out_o;
  logic [2:0]  field_class_o;
  logic [23:0] record_index_o;
  logic        record_done_o;
  logic [15:0] label_length_out_o;
  logic [15:0] version_out_o;
  logic [31:0] payload_size_out_o;
  logic [2:0]  error_code_o;
  logic        file_ok_o;

  record_scoreboard sb;
  bit               calm;
  int               hold_count;
  int               cut_left;
  int               sent_items;
  int               settings;

  chunk_record_parser uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .byte_out_o         (byte_out_o),
    .field_class_o      (field_class_o),
    .record_index_o     (record_index_o),
    .record_done_o      (record_done_o),
    .label_length_out_o (label_length_out_o),
    .version_out_o      (version_out_o),
    .payload_size_out_o (payload_size_out_o),
    .error_code_o       (error_code_o),
    .file_ok_o          (file_ok_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin : watchdog
    #16_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic sender_gap();
    int r;
    int gap;
    gap = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(8, 30);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Leaves valid high; the next request or an idle step must follow in this step.
  task automatic push_byte(crp_pkg::cmd_e cmd, logic [7:0] b);
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(cmd, b);
    sent_items++;
    sender_gap();
  endtask

  task automatic send_eof();
    push_byte(crp_pkg::CMD_EOF, 8'($urandom));
  endtask

  // Honors cut_left: stop the record after that many bytes (negative means whole).
  task automatic emit(logic [7:0] b);
    if (cut_left != 0) begin
      push_byte(crp_pkg::CMD_DATA, b);
      if (cut_left > 0) cut_left--;
    end
  endtask

  task automatic send_record(logic [15:0] len, logic [15:0] ver, logic [31:0] size);
    longint i;
    emit(len[7:0]);
    emit(len[15:8]);
    for (i = 0; i < len && cut_left != 0; i++) emit(8'($urandom));
    emit(ver[7:0]);
    emit(ver[15:8]);
    emit(size[7:0]);
    emit(size[15:8]);
    emit(size[23:16]);
    emit(size[31:24]);
    for (i = 0; i < size && cut_left != 0; i++) emit(8'($urandom));
  endtask

  // Hold the sender until every pending result has been seen.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic settle_idle();
    wait_results();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [31:0] nbytes, logic [31:0] nrecs);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= crp_pkg::CFG_MAX_FILE_BYTES;
    cfg_data_i  <= nbytes;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_limit(crp_pkg::CFG_MAX_FILE_BYTES, nbytes);
    cfg_index_i <= crp_pkg::CFG_MAX_RECORDS;
    cfg_data_i  <= nrecs;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_limit(crp_pkg::CFG_MAX_RECORDS, nrecs);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return 16'($urandom_range(1, 4));
    if (r < 97) return 16'($urandom_range(5, 40));
    return 16'($urandom_range(200, 300));
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'd0;
    if (r < 90) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 60);
    return $urandom_range(256, 400);
  endfunction

  task automatic random_file();
    int          kind;
    int          r;
    logic [15:0] len;
    logic [31:0] size;
    longint      full_len;
    longint      reach;
    calm = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 99);
    cut_left = -1;
    if (kind < 72) begin
      repeat ($urandom_range(1, 4)) begin
        send_record(pick_len(), 16'($urandom), pick_size());
        if ($urandom_range(0, 29) == 0) wait_results();
      end
    end else if (kind < 86) begin
      repeat ($urandom_range(0, 2)) send_record(pick_len(), 16'($urandom), pick_size());
      r = $urandom_range(0, 99);
      if (r < 10) len = 16'hFFFF;
      else if (r < 25) len = 16'($urandom_range(1, 65535));
      else len = pick_len();
      r = $urandom_range(0, 99);
      if (r < 15) size = 32'hFFFF_FFFF;
      else if (r < 40) size = $urandom;
      else size = pick_size();
      full_len = 64'd8 + len + size;
      reach = 64'd8 + len + ((size > 30) ? 30 : size);
      if (len > 300) reach = 64'd40;
      if (reach > full_len - 1) reach = full_len - 1;
      cut_left = $urandom_range(1, int'(reach));
      send_record(len, 16'($urandom), size);
      cut_left = -1;
    end else if (kind < 92) begin
      if ($urandom_range(0, 1) == 1) send_record(pick_len(), 16'($urandom), pick_size());
      push_byte(crp_pkg::CMD_DATA, 8'h00);
      push_byte(crp_pkg::CMD_DATA, 8'h00);
      repeat ($urandom_range(0, 4)) push_byte(crp_pkg::CMD_DATA, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 24)) push_byte(crp_pkg::CMD_DATA, 8'($urandom));
    end
    send_eof();
  endtask

  // Result side: check each accepted result, then pick the stall for the next cycle.
  initial begin : result_sink
    int               stall_left;
    int               hold_done;
    crp_pkg::result_t got;
    stall_left  = 0;
    hold_done   = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.byte_out     = byte_out_o;
        got.field_class  = crp_pkg::cls_e'(field_class_o);
        got.record_index = record_index_o;
        got.record_done  = record_done_o;
        got.label_len    = label_length_out_o;
        got.version      = version_out_o;
        got.pay_size     = payload_size_out_o;
        got.error_code   = crp_pkg::err_e'(error_code_o);
        got.file_ok      = file_ok_o;
        sb.check_result(got);
      end
      if (hold_count != hold_done) begin
        hold_done  = hold_count;
        stall_left = 400;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) :
                                                    $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int phase_goal;
    int round;
    sb = new();
    calm        = 1'b1;
    hold_count  = 0;
    cut_left    = -1;
    sent_items  = 0;
    settings    = 0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = crp_pkg::CFG_MAX_FILE_BYTES;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    cmd_i       = crp_pkg::CMD_DATA;
    data_byte_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty file, then a payload cut short by end of file.
    send_eof();
    cut_left = 9;
    send_record(16'h0001, 16'hFFFF, 32'h0000_0001);
    cut_left = -1;
    send_eof();
    // zero label length, then a byte that must be dropped
    push_byte(crp_pkg::CMD_DATA, 8'h00);
    push_byte(crp_pkg::CMD_DATA, 8'h00);
    push_byte(crp_pkg::CMD_DATA, 8'hFF);
    send_eof();
    // end of file inside the length field, then inside the label
    push_byte(crp_pkg::CMD_DATA, 8'h01);
    send_eof();
    push_byte(crp_pkg::CMD_DATA, 8'h02);
    push_byte(crp_pkg::CMD_DATA, 8'h00);
    push_byte(crp_pkg::CMD_DATA, 8'hAA);
    send_eof();
    settle_idle();
    // every byte is over a zero-byte file limit
    set_limits(32'h0000_0000, 32'h0000_0000);
    push_byte(crp_pkg::CMD_DATA, 8'h01);
    send_eof();
    settle_idle();
    // empty payload closes the record on its size, and overruns a zero record limit
    set_limits(32'hFFFF_FFFF, 32'h0000_0000);
    send_record(16'h0001, 16'h0000, 32'h0000_0000);
    send_eof();

    for (round = 0; sent_items < 1100; round++) begin
      settle_idle();
      case (round % 5)
        0: set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: set_limits($urandom_range(20, 120), $urandom_range(0, 3));
        2: set_limits($urandom, $urandom);
        3: set_limits($urandom_range(100, 600), $urandom_range(1, 8));
        default: set_limits(32'hFFFF_FFFF, $urandom_range(2, 5));
      endcase
      if (round == 0) begin
        // stall the result side for a long stretch while a long file keeps coming
        calm = 1'b1;
        hold_count++;
        send_record(16'h0004, 16'($urandom), 32'd90);
        send_eof();
      end
      phase_goal = sent_items + 120;
      while (sent_items < phase_goal && sent_items < 1100) random_file();
    end

    calm = 1'b1;
    settle_idle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d files, %0d records closed, %0d results checked, %0d limit settings",
             sb.files, sb.records_closed, sb.checked, settings);
    $display("error codes reached (one bit per code): %b, mismatches: %0d",
             sb.errs_seen, sb.faults);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
